### src/cmem_pkg.sv
// Shared types and codes for the compare-exchange memory engine.
// No dependencies.
package cmem_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned CmpW   = 16;

  localparam logic [CountW-1:0] WordCountReset = 11'd1024;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_CMPX = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [CmpW-1:0] CMP_SWAP_GT = 16'd0;
  localparam logic [CmpW-1:0] CMP_SWAP_LT = 16'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic wr_first;
    logic wr_second;
    logic finish;
  } cmem_cmd_t;

  typedef struct packed {
    logic do_load;
    logic do_cmpx;
    logic do_read;
    logic swap_hit;
    logic out_free;
  } cmem_stat_t;

endpackage

### src/cmem_ctrl.sv
// Sequencer for the compare-exchange memory engine.
// Depends on cmem_pkg for the command and status structs.
module cmem_ctrl import cmem_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cmem_stat_t stat_i,
  output cmem_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.do_load) begin
          cmd_o.wr_first = 1'b1;
          state_d        = S_DONE;
        end else if (stat_i.do_cmpx || stat_i.do_read) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMP: begin
        if (stat_i.do_cmpx && stat_i.swap_hit) begin
          cmd_o.wr_first = 1'b1;
          state_d        = S_WR2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WR2: begin
        cmd_o.wr_second = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### src/cmem_dp.sv
// Datapath: word store, request decode, comparator and result register.
// Depends on cmem_pkg for codes and the command and status structs.
module cmem_dp import cmem_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic [1:0]        req_type_i,
  input  logic [CmpW-1:0]   cmp_type_i,
  input  logic [IdxW-1:0]   first_index_i,
  input  logic [IdxW-1:0]   second_index_i,
  input  logic [WordW-1:0]  load_value_i,
  input  cmem_cmd_t         cmd_i,
  output cmem_stat_t        stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  read_value_o,
  output logic              swapped_o,
  output logic [1:0]        status_o
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [20:0] DepthLim = 21'(STORE_DEPTH);

  logic [WordW-1:0] mem_q [STORE_DEPTH];

  logic [CountW-1:0] word_count_q;
  logic              op_load_q, op_cmpx_q, op_read_q, lt_q, sw_q;
  logic [1:0]        st_q;
  logic [AddrW-1:0]  a1_q, a2_q;
  logic [WordW-1:0]  val_q, rd_a_q, rd_b_q;
  logic              out_valid_q;
  logic [WordW-1:0]  out_value_q;
  logic              out_sw_q;
  logic [1:0]        out_st_q;

  logic              ok1, ok2;
  logic              op_load_d, op_cmpx_d, op_read_d;
  logic [1:0]        st_d;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [WordW-1:0]  mem_wdata;

  assign ok1 = ({1'b0, first_index_i} < word_count_q) && (21'(first_index_i) < DepthLim);
  assign ok2 = ({1'b0, second_index_i} < word_count_q) && (21'(second_index_i) < DepthLim);

  always_comb begin
    op_load_d = 1'b0;
    op_cmpx_d = 1'b0;
    op_read_d = 1'b0;
    st_d      = ST_OK;
    case (req_type_i)
      REQ_LOAD: begin
        if (ok1) op_load_d = 1'b1;
        else     st_d      = ST_BAD_INDEX;
      end
      REQ_CMPX: begin
        if (!(ok1 && ok2))                                        st_d = ST_BAD_INDEX;
        else if (!(cmp_type_i inside {CMP_SWAP_GT, CMP_SWAP_LT})) st_d = ST_BAD_TYPE;
        else                                                      op_cmpx_d = 1'b1;
      end
      REQ_READ: begin
        if (ok1) op_read_d = 1'b1;
        else     st_d      = ST_BAD_INDEX;
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= WordCountReset;
      op_load_q    <= 1'b0;
      op_cmpx_q    <= 1'b0;
      op_read_q    <= 1'b0;
      sw_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) word_count_q <= cfg_wdata_i;
      if (cmd_i.capture) begin
        op_load_q <= op_load_d;
        op_cmpx_q <= op_cmpx_d;
        op_read_q <= op_read_d;
        sw_q      <= 1'b0;
      end else if (cmd_i.wr_first && op_cmpx_q) begin
        sw_q <= 1'b1;
      end
      if (cmd_i.finish)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      st_q  <= st_d;
      lt_q  <= (cmp_type_i == CMP_SWAP_LT);
      a1_q  <= AddrW'(first_index_i);
      a2_q  <= AddrW'(second_index_i);
      val_q <= load_value_i;
    end
    if (cmd_i.finish) begin
      out_value_q <= op_read_q ? rd_a_q : '0;
      out_sw_q    <= sw_q;
      out_st_q    <= st_q;
    end
  end

  assign mem_we    = cmd_i.wr_first || cmd_i.wr_second;
  assign mem_waddr = cmd_i.wr_second ? a2_q : a1_q;
  assign mem_wdata = cmd_i.wr_second ? rd_a_q : (op_load_q ? val_q : rd_b_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_q[a1_q];
      rd_b_q <= mem_q[a2_q];
    end
  end

  assign stat_o.do_load  = op_load_q;
  assign stat_o.do_cmpx  = op_cmpx_q;
  assign stat_o.do_read  = op_read_q;
  assign stat_o.swap_hit = lt_q ? (rd_a_q < rd_b_q) : (rd_a_q > rd_b_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign swapped_o    = out_sw_q;
  assign status_o     = out_st_q;

endmodule

### src/compare_exchange_memory_engine.sv
// Top level of the compare-exchange memory engine.
// Depends on cmem_pkg, cmem_ctrl and cmem_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request item: load a
//   word, compare-exchange two words, or read a word. Output channel
//   (out_valid_o/out_ready_i) returns one result item per request: read
//   value, swapped flag and status.
//   cfg_we_i/cfg_wdata_i write word_count; write only while idle.
//   From accept to result valid the sequencer passes EXEC and DONE for
//   load, error or ignored items; EXEC, CMP and DONE for read and
//   non-swapping compare-exchange; EXEC, CMP, WR2 and DONE for a
//   swapping compare-exchange (one write port: the pair is written back in
//   CMP and WR2). One item is in flight at a time.
//   The result register holds its item while out_ready_i is low; a finished
//   item waits in the sequencer until the register frees, and no new item is
//   taken meanwhile.
//   Reset sets word_count to 1024 and empties the result register; store
//   contents are undefined until loaded. No clearing pass is needed.
module compare_exchange_memory_engine import cmem_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [CmpW-1:0]   cmp_type_i,
  input  logic [IdxW-1:0]   first_index_i,
  input  logic [IdxW-1:0]   second_index_i,
  input  logic [WordW-1:0]  load_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  read_value_o,
  output logic              swapped_o,
  output logic [1:0]        status_o
);

  cmem_cmd_t  cmd;
  cmem_stat_t stat;

  cmem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cmem_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .cmp_type_i     (cmp_type_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .load_value_i   (load_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .swapped_o      (swapped_o),
    .status_o       (status_o)
  );

  a_swap_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && swapped_o |-> status_o == ST_OK)
    else $error("swap reported with error status");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == '0 && !swapped_o)
    else $error("error result carries data");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new item taken while one is in flight");

endmodule
